FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define WSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define WSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/wse_pkg.sv
package wse_pkg;

  localparam int LEVEL_W     = 8;
  localparam int BRIGHT_W    = 7;
  localparam int PROD_W      = LEVEL_W + BRIGHT_W;
  localparam int COLOUR_W    = 3 * LEVEL_W;
  localparam int SYM_W       = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SYM_W-1:0]    SYM_ONE      = 3'b110;
  localparam logic [SYM_W-1:0]    SYM_ZERO     = 3'b100;
  localparam logic [BRIGHT_W-1:0] FULL_SCALE   = 7'd100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd20;

  // floor(p / 100) == (p * 5243) >> 19 for every p up to 255 * 100
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = 13'd5243;
  localparam int                RECIP_SHIFT = 19;

  // register index decoded from paddr[2]
  localparam logic REG_BRIGHTNESS = 1'b0;

  typedef struct packed {
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] blue_level;
  } pixel_t;

endpackage

FILE: rtl/wse_if.sv
interface wse_pix_if;
  import wse_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] blue_level;

  modport source (output valid, green_level, red_level, blue_level, input ready);
  modport sink   (input valid, green_level, red_level, blue_level, output ready);
endinterface

interface wse_sym_if;
  import wse_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] line_symbol;
  logic             last_symbol;

  modport source (output valid, line_symbol, last_symbol, input ready);
  modport sink   (input valid, line_symbol, last_symbol, output ready);
endinterface

FILE: rtl/ws2812_pixel_symbol_encoder_top.sv
// WS2812 pixel symbol encoder: a pixel beat (green, red, blue levels) is scaled by
// the brightness register (level * brightness / 100, truncated; a write whose low
// seven bits exceed 100 is stored as 100, reset value 20), packed green-red-blue
// and sent out as PIXEL_BITS symbol beats, msb first, 110 for a one and 100 for a
// zero, with last_symbol set on the final beat. When PIXEL_BITS is above 24 the
// leading extra positions go out as zero symbols. Throughput is one symbol per
// cycle while the output keeps ready high; this is set by the output shift
// register, which sends one bit per cycle, and the next pixel loads as the last
// beat of the one before leaves. A pixel passes from the input register through
// the multiply into the product register, then through the reciprocal divide
// into the shift register, where its first symbol is presented. The two scaler
// stages hold up to two further pixels, so input beats are still taken while a
// pixel is shifting out until both are full. Brightness sits at byte address 0
// of the apb port; write it only while the block is empty.
`include "assert_macros.svh"

module ws2812_pixel_symbol_encoder_top #(
  parameter int PIXEL_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wse_pix_if.sink                            in_chan,
  wse_sym_if.source                          out_chan,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wse_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [wse_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [wse_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import wse_pkg::*;

  localparam int CW = $clog2(PIXEL_BITS);

  // configuration
  logic [BRIGHT_W-1:0] bright_r;
  logic [BRIGHT_W-1:0] bright_nxt;
  logic                cfg_wr;

  // scaler handshake
  pixel_t              pix;
  logic                sc_valid;
  logic                sc_ready;
  logic [COLOUR_W-1:0] sc_word;

  // serializer
  logic [PIXEL_BITS-1:0] shift_r;
  logic [CW-1:0]         cnt_r;
  logic                  s_v_r;
  logic                  last;
  logic                  out_acc;
  logic                  s_free;
  logic                  s_load;

  // ---------------- apb register ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // clamp on write so the stored value never passes full scale
  always_comb begin
    bright_nxt = cfg_pwdata[BRIGHT_W-1:0];
    if (bright_nxt > FULL_SCALE) begin
      bright_nxt = FULL_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_BRIGHTNESS) begin
      bright_r <= bright_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_BRIGHTNESS) ?
                      CFG_DATA_W'(bright_r) : '0;

  // ---------------- scaling pipeline ----------------
  assign pix.green_level = in_chan.green_level;
  assign pix.red_level   = in_chan.red_level;
  assign pix.blue_level  = in_chan.blue_level;

  wse_scaler u_scaler (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (in_chan.valid),
    .pix_ready  (in_chan.ready),
    .pix        (pix),
    .bright     (bright_r),
    .word_valid (sc_valid),
    .word_ready (sc_ready),
    .word       (sc_word)
  );

  // ---------------- symbol serializer ----------------
  // the shift register is free when empty or when its last beat leaves now
  assign last     = (cnt_r == CW'(PIXEL_BITS - 1));
  assign out_acc  = out_chan.valid && out_chan.ready;
  assign s_free   = !s_v_r || (out_acc && last);
  assign sc_ready = s_free;
  assign s_load   = sc_valid && s_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r   <= 1'b0;
      cnt_r   <= '0;
      shift_r <= '0;
    end else if (s_load) begin
      // packed word lands in the low bits, extra msbs read as zero
      s_v_r   <= 1'b1;
      cnt_r   <= '0;
      shift_r <= PIXEL_BITS'(sc_word);
    end else if (out_acc) begin
      shift_r <= shift_r << 1;
      cnt_r   <= cnt_r + CW'(1);
      if (last) begin
        s_v_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = s_v_r;
  assign out_chan.line_symbol = shift_r[PIXEL_BITS-1] ? SYM_ONE : SYM_ZERO;
  assign out_chan.last_symbol = last;

  // ---------------- checks ----------------
  `WSE_ASSERT_NOW(a_bright_clamped, clk, rst_n, 1'b1, bright_r <= FULL_SCALE)
  `WSE_ASSERT_NEXT(a_load_restarts, clk, rst_n, s_load, s_v_r && cnt_r == '0)
  `WSE_ASSERT_NEXT(a_count_steps, clk, rst_n, out_acc && !last, s_v_r && cnt_r == $past(cnt_r) + CW'(1))
  `WSE_ASSERT_NEXT(a_drain_idle, clk, rst_n, out_acc && last && !sc_valid, !s_v_r)

endmodule

FILE: rtl/wse_scaler.sv
module wse_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  wse_pkg::pixel_t                   pix,
  input  logic [wse_pkg::BRIGHT_W-1:0]      bright,
  output logic                              word_valid,
  input  logic                              word_ready,
  output logic [wse_pkg::COLOUR_W-1:0]      word
);
  import wse_pkg::*;

  localparam int QW = PROD_W + RECIP_W;

  logic               a_v_r;
  pixel_t             a_pix_r;
  logic               b_v_r;
  logic [PROD_W-1:0]  b_prod_r [3];
  logic               a_ready;
  logic               b_ready;
  logic [PROD_W-1:0]  prod [3];
  logic [LEVEL_W-1:0] quot [3];

  assign b_ready   = !b_v_r || word_ready;
  assign a_ready   = !a_v_r || b_ready;
  assign pix_ready = a_ready;

  // stage a: capture pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pix_valid) begin
      a_pix_r <= pix;
    end
  end

  // channel times brightness
  assign prod[0] = PROD_W'(a_pix_r.green_level) * PROD_W'(bright);
  assign prod[1] = PROD_W'(a_pix_r.red_level)   * PROD_W'(bright);
  assign prod[2] = PROD_W'(a_pix_r.blue_level)  * PROD_W'(bright);

  // stage b: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_prod_r <= prod;
    end
  end

  // divide by 100 through the reciprocal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot[i] = LEVEL_W'((QW'(b_prod_r[i]) * QW'(RECIP_MUL)) >> RECIP_SHIFT);
    end
  end

  assign word_valid = b_v_r;
  assign word       = {quot[0], quot[1], quot[2]};

endmodule
